### hw/rtl/irc_pkg.sv
`default_nettype none
package irc_pkg;

  // Default sizes
  localparam int MAX_HOSTS_DEF        = 256;
  localparam int MAX_PACKET_BYTES_DEF = 1024;

  // Request codes
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_BYTE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  // Host reply status codes
  typedef enum logic [2:0] {
    ST_NO_REPLY    = 3'd0,
    ST_OK          = 3'd1,
    ST_TTL         = 3'd2,
    ST_UNREACH     = 3'd3,
    ST_BAD         = 3'd4,
    ST_SEND_FAILED = 3'd5,
    ST_UNKNOWN     = 3'd6
  } status_t;

  // ICMP type bytes
  localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
  localparam logic [7:0] TYPE_UNREACH    = 8'd3;
  localparam logic [7:0] TYPE_ECHO_REQ   = 8'd8;
  localparam logic [7:0] TYPE_TTL        = 8'd11;

  // Offsets relative to the IPv4 header length
  localparam int ICMP_HDR_LEN   = 8;
  localparam int EMB_MIN_LEN    = 36;
  localparam int EMB_ADDR_FIRST = 24;
  localparam int EMB_ADDR_LAST  = 27;

  localparam int PEND_W = 9;

  // Classified request from front to back
  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    status_t     cls;
    logic [7:0]  raw;
    logic        echo;
  } cmd_t;

  // Result record
  typedef struct packed {
    status_t           status;
    logic [7:0]        raw;
    logic [31:0]       target;
    logic              matched;
    logic              changed;
    logic [PEND_W-1:0] pending;
    logic              all;
    logic              rejected;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CMP,
    BK_DONE
  } bk_state_t;

  function automatic status_t type_class(input logic [7:0] t);
    status_t s;
    s = ST_UNKNOWN;
    if (t == TYPE_ECHO_REPLY) s = ST_OK;
    else if (t == TYPE_UNREACH) s = ST_UNREACH;
    else if (t == TYPE_TTL) s = ST_TTL;
    return s;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/icmp_reply_classifier_host_table_unit.sv
// Channel   Direction  Handshake        Payload
// in_       request    in_push/in_full  op, data_byte, last_byte, sender_addr, host_addr
// out_      result     out_pop/out_empty status .. rejected
//
// Packet bytes that are not the last of a packet stay in the front end, with no table search.
// Add, mark, query and a packet's last byte search the host table entry by
// entry over the RAM read port, with a read state and a compare state per entry.
// A two-entry request queue lets bytes keep flowing while the search runs.
// Synchronous active-low reset empties the table, counters and queues.
// A waiting result stalls the final update step; once the request queue is
// full, every input request stalls as well.
`default_nettype none
module icmp_reply_classifier_host_table_unit
  import irc_pkg::*;
#(
  parameter int MAX_HOSTS        = MAX_HOSTS_DEF,
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic [31:0] in_sender_addr,
  input  wire logic [31:0] in_host_addr,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_status,
  output logic [7:0]       out_raw_type,
  output logic [31:0]      out_target_addr,
  output logic             out_matched,
  output logic             out_changed,
  output logic [8:0]       out_pending_count,
  output logic             out_all_answered,
  output logic             out_rejected
);

  logic acc, cmd_valid, q_full, q_empty, q_pop;
  cmd_t cmd, q_head;
  res_t res;

  assign acc     = in_push && !q_full;
  assign in_full = q_full;

  irc_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .op          (in_op),
    .data_byte   (in_data_byte),
    .last_byte   (in_last_byte),
    .sender_addr (in_sender_addr),
    .host_addr   (in_host_addr),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  irc_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_valid),
    .push_data (cmd),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  irc_back #(.MAX_HOSTS(MAX_HOSTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop && !out_empty),
    .out_empty (out_empty),
    .res       (res)
  );

  assign out_status        = res.status;
  assign out_raw_type      = res.raw;
  assign out_target_addr   = res.target;
  assign out_matched       = res.matched;
  assign out_changed       = res.changed;
  assign out_pending_count = res.pending;
  assign out_all_answered  = res.all;
  assign out_rejected      = res.rejected;

endmodule
`default_nettype wire

### hw/rtl/irc_ram.sv
`default_nettype none
module irc_ram #(
  parameter int W = 32,
  parameter int D = 256,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [W-1:0]  wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [W-1:0]  rd_data
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### hw/rtl/irc_front.sv
`default_nettype none
module irc_front
  import irc_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [31:0] sender_addr,
  input  wire logic [31:0] host_addr,
  output logic             cmd_valid,
  output cmd_t             cmd
);

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int XW = (PW > 7) ? PW + 1 : 8;

  logic [PW-1:0] pos_r;
  logic [5:0]    hl_r;
  logic [7:0]    type_r;
  logic [31:0]   emb_r;

  logic [5:0]    hl_cur;
  logic [7:0]    type_base, type_nxt;
  logic [31:0]   emb_base, emb_nxt;
  logic          in_range;
  logic [PW-1:0] cnt;
  logic [XW-1:0] pos_x, hl_x, cnt_x;
  logic          is_byte;
  status_t       cls;
  logic [31:0]   tgt;

  assign is_byte = (op_t'(op) == OP_BYTE);

  // Header assembly for the current byte
  always_comb begin
    hl_cur    = (pos_r == '0) ? {data_byte[3:0], 2'b00} : hl_r;
    type_base = (pos_r == '0) ? 8'd0 : type_r;
    emb_base  = (pos_r == '0) ? 32'd0 : emb_r;
    in_range  = (pos_r < PW'(MAX_PACKET_BYTES));
    pos_x     = XW'(pos_r);
    hl_x      = XW'(hl_cur);
    cnt       = in_range ? pos_r + PW'(1) : pos_r;
    cnt_x     = XW'(cnt);
    type_nxt  = (in_range && pos_x == hl_x) ? data_byte : type_base;
    emb_nxt   = (in_range && pos_x >= hl_x + XW'(EMB_ADDR_FIRST)
                 && pos_x <= hl_x + XW'(EMB_ADDR_LAST))
                ? {emb_base[23:0], data_byte} : emb_base;
  end

  // Packet classification on the last byte
  always_comb begin
    tgt = sender_addr;
    if (cnt_x >= hl_x + XW'(ICMP_HDR_LEN)) begin
      cls = type_class(type_nxt);
      if (type_nxt == TYPE_UNREACH || type_nxt == TYPE_TTL) begin
        if (cnt_x >= hl_x + XW'(EMB_MIN_LEN)) tgt = emb_nxt;
        else cls = ST_BAD;
      end
    end else begin
      cls = ST_BAD;
    end
  end

  // Request to the back end
  always_comb begin
    cmd_valid = acc && (!is_byte || last_byte);
    cmd.op    = op_t'(op);
    if (is_byte) begin
      cmd.addr = tgt;
      cmd.cls  = cls;
      cmd.raw  = type_nxt;
      cmd.echo = (cls != ST_BAD) && (type_nxt == TYPE_ECHO_REQ);
    end else begin
      cmd.addr = host_addr;
      cmd.cls  = ST_NO_REPLY;
      cmd.raw  = 8'd0;
      cmd.echo = 1'b0;
    end
  end

  // Byte position and packet state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (acc && is_byte) begin
      pos_r <= last_byte ? '0 : cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_byte) begin
      hl_r   <= hl_cur;
      type_r <= type_nxt;
      emb_r  <= emb_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/irc_cmdq.sv
`default_nettype none
module irc_cmdq
  import irc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output cmd_t      head
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // Two-entry request queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

### hw/rtl/irc_back.sv
`default_nettype none
module irc_back
  import irc_pkg::*;
#(
  parameter int MAX_HOSTS = MAX_HOSTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire cmd_t q_head,
  output logic      q_pop,
  input  wire logic out_pop,
  output logic      out_empty,
  output res_t      res
);

  localparam int CW = $clog2(MAX_HOSTS + 1);
  localparam int IW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;

  bk_state_t state_r, state_nxt;
  cmd_t      cmd_r, cmd_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] hcnt_r, hcnt_nxt;
  logic [CW-1:0] pend_r, pend_nxt;
  status_t   stat_r, stat_nxt;
  logic      found_r, found_nxt;
  logic      out_valid_r, out_valid_nxt;
  res_t      out_r, out_nxt;

  logic          out_free;
  logic [31:0]   addr_rd;
  logic [2:0]    stat_rd;
  logic          we_addr, we_stat;
  status_t       wr_stat;
  logic [CW+8:0] pend_ext;
  res_t          r;

  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign res       = out_r;
  assign q_pop     = (state_r == BK_IDLE) && !q_empty;

  // Host address and status tables
  irc_ram #(.W(32), .D(MAX_HOSTS)) u_addr_ram (
    .clk     (clk),
    .wr_en   (we_addr),
    .wr_addr (idx_r[IW-1:0]),
    .wr_data (cmd_r.addr),
    .rd_addr (idx_r[IW-1:0]),
    .rd_data (addr_rd)
  );

  irc_ram #(.W(3), .D(MAX_HOSTS)) u_stat_ram (
    .clk     (clk),
    .wr_en   (we_stat),
    .wr_addr (idx_r[IW-1:0]),
    .wr_data (wr_stat),
    .rd_addr (idx_r[IW-1:0]),
    .rd_data (stat_rd)
  );

  // Next state: linear search, then one update step
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_READ;
      BK_READ: state_nxt = (idx_r == hcnt_r) ? BK_DONE : BK_CMP;
      BK_CMP:  state_nxt = (addr_rd == cmd_r.addr) ? BK_DONE : BK_READ;
      BK_DONE: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and table updates
  always_comb begin
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    hcnt_nxt      = hcnt_r;
    pend_nxt      = pend_r;
    stat_nxt      = stat_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_nxt       = out_r;
    we_addr       = 1'b0;
    we_stat       = 1'b0;
    wr_stat       = ST_NO_REPLY;
    r             = '0;
    r.raw         = cmd_r.raw;
    r.target      = cmd_r.addr;
    pend_ext      = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          cmd_nxt   = q_head;
          idx_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      BK_READ: ;
      BK_CMP: begin
        if (addr_rd == cmd_r.addr) begin
          found_nxt = 1'b1;
          stat_nxt  = status_t'(stat_rd);
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      BK_DONE: begin
        if (out_free) begin
          unique case (cmd_r.op)
            OP_BYTE: begin
              r.status  = cmd_r.cls;
              r.matched = found_r;
              if (found_r && !cmd_r.echo && stat_r != ST_OK) begin
                if (stat_r == ST_NO_REPLY && pend_r != '0) pend_nxt = pend_r - CW'(1);
                we_stat   = 1'b1;
                wr_stat   = cmd_r.cls;
                r.changed = 1'b1;
                r.all     = (pend_nxt == '0);
              end
            end
            OP_ADD: begin
              if (cmd_r.addr == 32'd0 || cmd_r.addr == 32'hFFFF_FFFF) begin
                r.rejected = 1'b1;
              end else if (found_r) begin
                r.matched = 1'b1;
                r.changed = 1'b1;
                if (stat_r != ST_NO_REPLY) pend_nxt = pend_r + CW'(1);
                we_stat   = 1'b1;
              end else if (hcnt_r >= CW'(MAX_HOSTS)) begin
                r.rejected = 1'b1;
              end else begin
                we_addr   = 1'b1;
                we_stat   = 1'b1;
                hcnt_nxt  = hcnt_r + CW'(1);
                pend_nxt  = pend_r + CW'(1);
                r.matched = 1'b1;
                r.changed = 1'b1;
              end
            end
            OP_MARK: begin
              if (found_r) begin
                r.matched = 1'b1;
                r.status  = stat_r;
                if (stat_r == ST_NO_REPLY) begin
                  we_stat   = 1'b1;
                  wr_stat   = ST_SEND_FAILED;
                  if (pend_r != '0) pend_nxt = pend_r - CW'(1);
                  r.changed = 1'b1;
                  r.all     = (pend_nxt == '0);
                  r.status  = ST_SEND_FAILED;
                end
              end
            end
            OP_QUERY: begin
              if (found_r) begin
                r.matched = 1'b1;
                r.status  = stat_r;
              end
            end
            default: ;
          endcase
          pend_ext      = {9'd0, pend_nxt};
          r.pending     = pend_ext[PEND_W-1:0];
          out_valid_nxt = 1'b1;
          out_nxt       = r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      hcnt_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hcnt_r      <= hcnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    stat_r  <= stat_nxt;
    found_r <= found_nxt;
    out_r   <= out_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/irc_checker.sv
`default_nettype none
module irc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_target_addr,
  input wire logic        out_matched,
  input wire logic        out_changed,
  input wire logic [8:0]  out_pending_count,
  input wire logic        out_all_answered,
  input wire logic        out_rejected
);

  // No result survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  // A result not taken holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status)
      && $stable(out_target_addr) && $stable(out_pending_count)))
    else $error("waiting result changed");

  // All answered only with an update and nothing pending
  a_all: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_all_answered) |-> (out_changed && out_pending_count == 9'd0))
    else $error("all_answered inconsistent");

  // A refused add touches no entry
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_rejected) |-> (!out_matched && !out_changed))
    else $error("rejected add reports an entry");

endmodule

bind icmp_reply_classifier_host_table_unit irc_checker u_irc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_status        (out_status),
  .out_target_addr   (out_target_addr),
  .out_matched       (out_matched),
  .out_changed       (out_changed),
  .out_pending_count (out_pending_count),
  .out_all_answered  (out_all_answered),
  .out_rejected      (out_rejected)
);
`default_nettype wire
